// ----- rtl/bus_frame_receiver_router_macros.svh -----
// Assertion macros for the bus frame receiver and router.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef BUS_FRAME_RECEIVER_ROUTER_MACROS_SVH
`define BUS_FRAME_RECEIVER_ROUTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BFRR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfrr assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BFRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfrr assertion failed");

`endif

// ----- rtl/bfrr_pkg.sv -----
// Types and constants of the bus frame receiver and router.
// No dependencies; imported by bus_frame_receiver_router and its bench.
package bfrr_pkg;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_ANNOUNCE = 3'd1,
    KIND_DISPLAY  = 3'd2,
    KIND_CMD_0A   = 3'd3,
    KIND_CMD_0B   = 3'd4,
    KIND_CMD_0C   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    EV_SKIP     = 3'd0,
    EV_TAKEN    = 3'd1,
    EV_END_OK   = 3'd2,
    EV_END_BAD  = 3'd3,
    EV_REJECT   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ROUTE_NONE     = 2'd0,
    ROUTE_DATA     = 2'd1,
    ROUTE_DISPLAY  = 2'd2,
    ROUTE_ANNOUNCE = 2'd3
  } route_t;

  typedef enum logic [2:0] {
    CFG_ENABLED   = 3'd0,
    CFG_DATA_MAX  = 3'd1,
    CFG_ANN_MAX   = 3'd2,
    CFG_CMD_MAX   = 3'd3,
    CFG_DISP_MAX  = 3'd4
  } cfg_reg_t;

  localparam logic [7:0] SYNC_DATA     = 8'hFC;
  localparam logic [7:0] SYNC_ANNOUNCE = 8'hFD;
  localparam logic [7:0] SYNC_DISPLAY  = 8'h0F;
  localparam logic [7:0] SYNC_CMD_0A   = 8'h0A;
  localparam logic [7:0] SYNC_CMD_0B   = 8'h0B;
  localparam logic [7:0] SYNC_CMD_0C   = 8'h0C;

  localparam logic [7:0] DISP_HDR_ONE   = 8'h22;
  localparam logic [7:0] DISP_HDR_TWO   = 8'h04;
  localparam logic [7:0] DISP_HDR_THREE = 8'h00;
  localparam logic [7:0] ANN_HDR_ONE    = 8'h05;
  localparam logic [7:0] ANN_HDR_TWO    = 8'hAA;
  localparam logic [7:0] ANN_TOTAL      = 8'd8;

  localparam logic [7:0] FUNC_0B = 8'h0B;
  localparam logic [7:0] FUNC_0C = 8'h0C;
  localparam logic [7:0] FUNC_0D = 8'h0D;
  localparam logic [7:0] FUNC_24 = 8'h24;
  localparam logic [7:0] SUB_01  = 8'h01;
  localparam logic [7:0] SUB_02  = 8'h02;

  // Decoder bits of the route mask.
  localparam logic [6:0] DEC_AQUA      = 7'h01;
  localparam logic [6:0] DEC_AQUA2     = 7'h02;
  localparam logic [6:0] DEC_MODULA    = 7'h04;
  localparam logic [6:0] DEC_ESPRESSO  = 7'h08;
  localparam logic [6:0] DEC_PALLETTI2 = 7'h10;
  localparam logic [6:0] DEC_COMPACT   = 7'h20;
  localparam logic [6:0] DEC_COMFORT   = 7'h40;

  localparam logic [7:0] RESET_DATA_MAX = 8'd64;
  localparam logic [7:0] RESET_ANN_MAX  = 8'd64;
  localparam logic [7:0] RESET_CMD_MAX  = 8'd128;
  localparam logic [7:0] RESET_DISP_MAX = 8'd64;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } sync_t;

  function automatic sync_t sync_decode(input logic [7:0] b);
    sync_t s;
    s.hit  = 1'b1;
    s.kind = KIND_DATA;
    unique case (b)
      SYNC_DATA:     s.kind = KIND_DATA;
      SYNC_ANNOUNCE: s.kind = KIND_ANNOUNCE;
      SYNC_DISPLAY:  s.kind = KIND_DISPLAY;
      SYNC_CMD_0A:   s.kind = KIND_CMD_0A;
      SYNC_CMD_0B:   s.kind = KIND_CMD_0B;
      SYNC_CMD_0C:   s.kind = KIND_CMD_0C;
      default:       s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/bus_frame_receiver_router.sv -----
// Bus frame receiver and router: sync search, length check, checksum and routing.
// A result sits in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; in_stall rises only when the output register
// is full and the downstream side stalls it.
// Reset (rst, synchronous): seeking sync, output empty, limits at their defaults.
// Depends on bfrr_pkg and bus_frame_receiver_router_macros.svh.
`include "bus_frame_receiver_router_macros.svh"

module bus_frame_receiver_router #(
  parameter int MAX_FRAME_BYTES = 131
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [2:0] frame_kind,
  output logic [7:0] byte_value,
  output logic [7:0] byte_index,
  output logic       is_payload,
  output logic [7:0] frame_total,
  output logic       sum_good,
  output logic [6:0] route_mask,
  output logic [1:0] route_kind,
  output logic [7:0] function_high,
  output logic [7:0] function_low
);
  import bfrr_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = CNT_W + 8;
  localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(MAX_FRAME_BYTES - 3);

  // Configuration registers
  logic [6:0] enabled_devices;
  logic [7:0] data_frame_max_len;
  logic [7:0] announce_max_len;
  logic [7:0] command_max_len;
  logic [7:0] display_max_len;

  // Frame state
  logic             collecting, collecting_next;
  kind_t            kind_reg, kind_reg_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] total_len, total_len_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       header_one, header_one_next;
  logic [7:0]       header_two, header_two_next;
  logic [7:0]       header_three, header_three_next;

  // Result values computed for the byte at the input
  event_t     res_event;
  kind_t      res_kind;
  logic [7:0] res_index;
  logic       res_payload;
  logic [7:0] res_total;
  logic       res_ok;
  logic [6:0] res_mask;
  route_t     res_route;
  logic [7:0] res_fhigh;
  logic [7:0] res_flow;

  sync_t            sync_hit;
  logic             accept;
  logic [7:0]       len_hi_cfg;
  logic             len_ok;
  logic [CNT_W-1:0] total_eff;
  logic [7:0]       h_two_eff;
  logic [7:0]       h_three_eff;
  logic [6:0]       mask_raw;
  route_t           route_raw;
  logic             sum_match;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign sync_hit  = sync_decode(rx_byte);

  // Frame total and header bytes as seen with the byte at the input included.
  assign total_eff   = (byte_count == CNT_W'(1)) ? CNT_W'(3) + CNT_W'(rx_byte) : total_len;
  assign h_two_eff   = (byte_count == CNT_W'(2)) ? rx_byte : header_two;
  assign h_three_eff = (byte_count == CNT_W'(3)) ? rx_byte : header_three;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_devices    <= '0;
      data_frame_max_len <= RESET_DATA_MAX;
      announce_max_len   <= RESET_ANN_MAX;
      command_max_len    <= RESET_CMD_MAX;
      display_max_len    <= RESET_DISP_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLED:  enabled_devices    <= cfg_data[6:0];
        CFG_DATA_MAX: data_frame_max_len <= cfg_data;
        CFG_ANN_MAX:  announce_max_len   <= cfg_data;
        CFG_CMD_MAX:  command_max_len    <= cfg_data;
        CFG_DISP_MAX: display_max_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Length check for the byte at index 1, per frame kind.
  always_comb begin
    unique case (kind_reg)
      KIND_DATA:     len_hi_cfg = data_frame_max_len;
      KIND_ANNOUNCE: len_hi_cfg = announce_max_len;
      KIND_DISPLAY:  len_hi_cfg = display_max_len;
      default:       len_hi_cfg = command_max_len;
    endcase
    len_ok = (rx_byte <= len_hi_cfg) && (CMP_W'(rx_byte) <= CMP_W'(LEN_CAP));
    unique case (kind_reg)
      KIND_DATA:   len_ok = len_ok && (rx_byte >= 8'd2);
      KIND_CMD_0A: len_ok = len_ok && (rx_byte == 8'd1);
      default:     len_ok = len_ok && (rx_byte >= 8'd1);
    endcase
  end

  assign sum_match = (8'(~running_sum + 8'd1) == rx_byte);

  // Route mask and route kind from the header bytes, with the byte at index 3 taken from
  // the input when the frame ends right there.
  always_comb begin
    mask_raw  = '0;
    route_raw = ROUTE_NONE;
    unique case (kind_reg)
      KIND_DATA: begin
        route_raw = ROUTE_DATA;
        if (h_three_eff == SUB_01) begin
          if (h_two_eff == FUNC_0B) mask_raw = DEC_AQUA;
          if (h_two_eff == FUNC_24) mask_raw = DEC_AQUA2;
          if (h_two_eff == FUNC_0C) mask_raw = DEC_MODULA | DEC_ESPRESSO | DEC_PALLETTI2;
          if (h_two_eff == FUNC_0D) mask_raw = DEC_COMPACT;
        end else if (h_three_eff == SUB_02 && h_two_eff == FUNC_0C) begin
          mask_raw = DEC_COMFORT;
        end
      end
      KIND_DISPLAY: begin
        if (header_one == DISP_HDR_ONE && h_two_eff == DISP_HDR_TWO &&
            h_three_eff == DISP_HDR_THREE) begin
          route_raw = ROUTE_DISPLAY;
          mask_raw  = DEC_AQUA | DEC_PALLETTI2;
        end
      end
      KIND_ANNOUNCE: begin
        if (total_eff == CNT_W'(ANN_TOTAL) && header_one == ANN_HDR_ONE &&
            h_two_eff == ANN_HDR_TWO) begin
          route_raw = ROUTE_ANNOUNCE;
          if (h_three_eff == FUNC_0B) mask_raw = DEC_AQUA;
          else if (h_three_eff == FUNC_0C) mask_raw = DEC_COMFORT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    collecting_next   = collecting;
    kind_reg_next     = kind_reg;
    byte_count_next   = byte_count;
    total_len_next    = total_len;
    running_sum_next  = running_sum;
    header_one_next   = header_one;
    header_two_next   = header_two;
    header_three_next = header_three;

    res_event   = EV_SKIP;
    res_kind    = KIND_DATA;
    res_index   = '0;
    res_payload = 1'b0;
    res_total   = '0;
    res_ok      = 1'b0;
    res_mask    = '0;
    res_route   = ROUTE_NONE;
    res_fhigh   = '0;
    res_flow    = '0;

    if (!collecting) begin
      if (sync_hit.hit) begin
        collecting_next   = 1'b1;
        kind_reg_next     = sync_hit.kind;
        byte_count_next   = CNT_W'(1);
        total_len_next    = '0;
        running_sum_next  = rx_byte;
        header_one_next   = '0;
        header_two_next   = '0;
        header_three_next = '0;
        res_event         = EV_TAKEN;
        res_kind          = sync_hit.kind;
      end
    end else begin
      res_kind  = kind_reg;
      res_index = 8'(byte_count);
      if (byte_count == CNT_W'(1) && !len_ok) begin
        // A rejected length byte is consumed and not rescanned for sync.
        collecting_next  = 1'b0;
        byte_count_next  = '0;
        total_len_next   = '0;
        running_sum_next = '0;
        res_event        = EV_REJECT;
      end else begin
        if (byte_count == CNT_W'(1)) begin
          total_len_next  = total_eff;
          header_one_next = rx_byte;
        end else if (byte_count == CNT_W'(2)) begin
          header_two_next = rx_byte;
        end else if (byte_count == CNT_W'(3)) begin
          header_three_next = rx_byte;
        end
        res_total = 8'(total_eff);
        if ((CNT_W + 1)'(byte_count) + (CNT_W + 1)'(1) < (CNT_W + 1)'(total_eff)) begin
          running_sum_next = running_sum + rx_byte;
          byte_count_next  = byte_count + CNT_W'(1);
          res_event        = EV_TAKEN;
          res_payload      = (byte_count >= CNT_W'(4)) &&
                             (kind_reg == KIND_DATA || kind_reg == KIND_DISPLAY);
        end else begin
          // Checksum byte: close the frame and route it whatever the sum says.
          collecting_next  = 1'b0;
          byte_count_next  = '0;
          total_len_next   = '0;
          running_sum_next = '0;
          res_event        = sum_match ? EV_END_OK : EV_END_BAD;
          res_ok           = sum_match;
          res_mask         = mask_raw & enabled_devices;
          res_route        = route_raw;
          res_fhigh        = h_two_eff;
          res_flow         = h_three_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting   <= 1'b0;
      kind_reg     <= KIND_DATA;
      byte_count   <= '0;
      total_len    <= '0;
      running_sum  <= '0;
      header_one   <= '0;
      header_two   <= '0;
      header_three <= '0;
    end else if (accept) begin
      collecting   <= collecting_next;
      kind_reg     <= kind_reg_next;
      byte_count   <= byte_count_next;
      total_len    <= total_len_next;
      running_sum  <= running_sum_next;
      header_one   <= header_one_next;
      header_two   <= header_two_next;
      header_three <= header_three_next;
    end
  end

  // Result register; a waiting result does not block the next byte unless
  // the downstream side stalls it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_res     <= res_event;
      frame_kind    <= res_kind;
      byte_value    <= rx_byte;
      byte_index    <= res_index;
      is_payload    <= res_payload;
      frame_total   <= res_total;
      sum_good      <= res_ok;
      route_mask    <= res_mask;
      route_kind    <= res_route;
      function_high <= res_fhigh;
      function_low  <= res_flow;
    end
  end

  `BFRR_ASSERT_IMPL(a_seek_count_clear, !collecting, byte_count == '0 && total_len == '0)
  `BFRR_ASSERT_IMPL(a_ok_matches_event, out_valid,
                    sum_good == (event_res == EV_END_OK))
  `BFRR_ASSERT_IMPL(a_no_route_midframe,
                    out_valid && (event_res == EV_SKIP || event_res == EV_TAKEN ||
                                  event_res == EV_REJECT),
                    route_mask == '0 && route_kind == ROUTE_NONE)
  `BFRR_ASSERT_NEXT(a_end_returns_seek,
                    accept && collecting && !collecting_next, !collecting)

endmodule

// ----- bench/tb_bus_frame_receiver_router.sv -----
// Self-checking bench for bus_frame_receiver_router: drives received bytes and checks every result.
// Depends on bfrr_pkg and the block's RTL; frame decoding is modeled inside the bench.
module tb_bus_frame_receiver_router;
  import bfrr_pkg::*;

  localparam int FRAME_BYTES_MAX = 131;
  localparam logic [7:0] LEN_CAP = 8'(FRAME_BYTES_MAX - 3);

  typedef struct packed {
    event_t     ev;
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] index;
    logic       payload;
    logic [7:0] total;
    logic       sum_ok;
    logic [6:0] mask;
    route_t     route;
    logic [7:0] func_high;
    logic [7:0] func_low;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_res;
  logic [2:0] frame_kind;
  logic [7:0] byte_value;
  logic [7:0] byte_index;
  logic       is_payload;
  logic [7:0] frame_total;
  logic       sum_good;
  logic [6:0] route_mask;
  logic [1:0] route_kind;
  logic [7:0] function_high;
  logic [7:0] function_low;

  bus_frame_receiver_router #(.MAX_FRAME_BYTES(FRAME_BYTES_MAX)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .frame_kind(frame_kind), .byte_value(byte_value),
    .byte_index(byte_index), .is_payload(is_payload), .frame_total(frame_total),
    .sum_good(sum_good), .route_mask(route_mask), .route_kind(route_kind),
    .function_high(function_high), .function_low(function_low)
  );

  // Receiver model state and register copies.
  bit         in_frame;
  kind_t      cur_kind;
  logic [7:0] next_index;
  logic [7:0] frame_len;
  logic [7:0] sum_acc;
  logic [7:0] hdr_len;
  logic [7:0] hdr_func;
  logic [7:0] hdr_sub;
  logic [6:0] en_mask;
  logic [7:0] max_data;
  logic [7:0] max_ann;
  logic [7:0] max_cmd;
  logic [7:0] max_disp;

  frame_result_t pending_results[$];
  int send_idle_pct;
  int stall_pct;
  int bytes_in_frames;
  int errors;
  int n_sum_ok;
  int n_sum_bad;
  int n_rejected;
  int n_skipped;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [7:0] sync_of(input kind_t k);
    case (k)
      KIND_DATA:     return SYNC_DATA;
      KIND_ANNOUNCE: return SYNC_ANNOUNCE;
      KIND_DISPLAY:  return SYNC_DISPLAY;
      KIND_CMD_0A:   return SYNC_CMD_0A;
      KIND_CMD_0B:   return SYNC_CMD_0B;
      default:       return SYNC_CMD_0C;
    endcase
  endfunction

  function automatic logic [7:0] upper_len(input kind_t k);
    logic [7:0] lim;
    case (k)
      KIND_DATA:     lim = max_data;
      KIND_ANNOUNCE: lim = max_ann;
      KIND_DISPLAY:  lim = max_disp;
      default:       lim = max_cmd;
    endcase
    return (lim < LEN_CAP) ? lim : LEN_CAP;
  endfunction

  function automatic logic [7:0] lower_len(input kind_t k);
    return (k == KIND_DATA) ? 8'd2 : 8'd1;
  endfunction

  // Frame total for a length byte, zero when the length is rejected.
  function automatic logic [7:0] total_for(input kind_t k, input logic [7:0] len);
    if (k == KIND_CMD_0A && len != 8'd1) return 8'd0;
    if (len < lower_len(k) || len > upper_len(k)) return 8'd0;
    return len + 8'd3;
  endfunction

  task automatic close_frame();
    in_frame = 1'b0;
    next_index = 8'd0;
    frame_len = 8'd0;
    sum_acc = 8'd0;
  endtask

  task automatic decode_rx_byte(input logic [7:0] b, output frame_result_t r);
    kind_t k;
    bit    hit;
    r = '0;
    r.value = b;
    if (!in_frame) begin
      hit = 1'b1;
      k = KIND_DATA;
      case (b)
        SYNC_DATA:     k = KIND_DATA;
        SYNC_ANNOUNCE: k = KIND_ANNOUNCE;
        SYNC_DISPLAY:  k = KIND_DISPLAY;
        SYNC_CMD_0A:   k = KIND_CMD_0A;
        SYNC_CMD_0B:   k = KIND_CMD_0B;
        SYNC_CMD_0C:   k = KIND_CMD_0C;
        default:       hit = 1'b0;
      endcase
      if (hit) begin
        in_frame = 1'b1;
        cur_kind = k;
        next_index = 8'd1;
        frame_len = 8'd0;
        sum_acc = b;
        hdr_len = 8'd0;
        hdr_func = 8'd0;
        hdr_sub = 8'd0;
        r.ev = EV_TAKEN;
        r.kind = k;
      end else begin
        r.ev = EV_SKIP;
      end
    end else begin
      r.kind = cur_kind;
      r.index = next_index;
      if (next_index == 8'd1) frame_len = total_for(cur_kind, b);
      if (frame_len == 8'd0) begin
        // The rejected length byte is consumed, not searched for sync.
        r.ev = EV_REJECT;
        close_frame();
      end else begin
        case (next_index)
          8'd1: hdr_len = b;
          8'd2: hdr_func = b;
          8'd3: hdr_sub = b;
          default: ;
        endcase
        r.total = frame_len;
        if (int'(next_index) + 1 < int'(frame_len)) begin
          sum_acc = sum_acc + b;
          r.ev = EV_TAKEN;
          r.payload = (next_index >= 8'd4) &&
                      (cur_kind == KIND_DATA || cur_kind == KIND_DISPLAY);
          next_index = next_index + 8'd1;
        end else begin
          // Routing does not depend on the checksum outcome.
          r.sum_ok = ((8'd0 - sum_acc) == b);
          r.ev = r.sum_ok ? EV_END_OK : EV_END_BAD;
          r.route = ROUTE_NONE;
          case (cur_kind)
            KIND_DATA: begin
              r.route = ROUTE_DATA;
              if (hdr_sub == SUB_01) begin
                if (hdr_func == FUNC_0B) r.mask |= DEC_AQUA;
                if (hdr_func == FUNC_24) r.mask |= DEC_AQUA2;
                if (hdr_func == FUNC_0C) r.mask |= DEC_MODULA | DEC_ESPRESSO | DEC_PALLETTI2;
                if (hdr_func == FUNC_0D) r.mask |= DEC_COMPACT;
              end else if (hdr_sub == SUB_02 && hdr_func == FUNC_0C) begin
                r.mask |= DEC_COMFORT;
              end
            end
            KIND_DISPLAY: begin
              if (hdr_len == DISP_HDR_ONE && hdr_func == DISP_HDR_TWO &&
                  hdr_sub == DISP_HDR_THREE) begin
                r.route = ROUTE_DISPLAY;
                r.mask = DEC_AQUA | DEC_PALLETTI2;
              end
            end
            KIND_ANNOUNCE: begin
              if (frame_len == ANN_TOTAL && hdr_len == ANN_HDR_ONE &&
                  hdr_func == ANN_HDR_TWO) begin
                r.route = ROUTE_ANNOUNCE;
                if (hdr_sub == FUNC_0B) r.mask = DEC_AQUA;
                else if (hdr_sub == FUNC_0C) r.mask = DEC_COMFORT;
              end
            end
            default: ;
          endcase
          r.mask &= en_mask;
          r.func_high = hdr_func;
          r.func_low = hdr_sub;
          close_frame();
        end
      end
    end
  endtask

  task automatic clear_model();
    close_frame();
    cur_kind = KIND_DATA;
    hdr_len = 8'd0;
    hdr_func = 8'd0;
    hdr_sub = 8'd0;
    en_mask = 7'd0;
    max_data = RESET_DATA_MAX;
    max_ann = RESET_ANN_MAX;
    max_cmd = RESET_CMD_MAX;
    max_disp = RESET_DISP_MAX;
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit            held;
    frame_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    decode_rx_byte(b, r);
    pending_results.insert(pending_results.size(), r);
    if (r.ev != EV_SKIP) bytes_in_frames++;
  endtask

  task automatic send_frame(input kind_t k, input logic [7:0] len, input logic [7:0] func,
                            input logic [7:0] sub, input bit set_hdr, input bit bad_sum);
    logic [7:0] body;
    logic [7:0] sum;
    sum = sync_of(k) + len;
    send_byte(sync_of(k));
    send_byte(len);
    for (int i = 0; i < int'(len); i++) begin
      body = 8'($urandom_range(255));
      if (set_hdr && i == 0) body = func;
      if (set_hdr && i == 1) body = sub;
      sum = sum + body;
      send_byte(body);
    end
    sum = 8'd0 - sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
    send_byte(sum);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    bit ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLED:  en_mask = val[6:0];
      CFG_DATA_MAX: max_data = val;
      CFG_ANN_MAX:  max_ann = val;
      CFG_CMD_MAX:  max_cmd = val;
      CFG_DISP_MAX: max_disp = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Every byte yields one result, so an empty queue means idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_limit(input int lo);
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'd128;
    if (r < 50) return 8'(lo);
    return 8'($urandom_range(128, lo));
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Output transactions are decided by signals that are stable at the falling edge.
  always @(negedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none actual event %0h byte %0h",
                   $time, event_res, byte_value);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        compare_field("event_res", 8'(want.ev), 8'(event_res));
        compare_field("frame_kind", 8'(want.kind), 8'(frame_kind));
        compare_field("byte_value", want.value, byte_value);
        compare_field("byte_index", want.index, byte_index);
        compare_field("is_payload", 8'(want.payload), 8'(is_payload));
        compare_field("frame_total", want.total, frame_total);
        compare_field("sum_good", 8'(want.sum_ok), 8'(sum_good));
        compare_field("route_mask", 8'(want.mask), 8'(route_mask));
        compare_field("route_kind", 8'(want.route), 8'(route_kind));
        compare_field("function_high", want.func_high, function_high);
        compare_field("function_low", want.func_low, function_low);
        case (want.ev)
          EV_END_OK:  n_sum_ok++;
          EV_END_BAD: n_sum_bad++;
          EV_REJECT:  n_rejected++;
          EV_SKIP:    n_skipped++;
          default: ;
        endcase
      end
    end
  end

  task automatic test_directed_frames();
    send_idle_pct = 24;
    stall_pct = 81;
    write_reg(CFG_ENABLED, 8'h7F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(KIND_DATA, 8'd2, FUNC_0C, SUB_01, 1'b1, 1'b0);
    send_frame(KIND_ANNOUNCE, ANN_HDR_ONE, ANN_HDR_TWO, FUNC_0B, 1'b1, 1'b0);
    send_frame(KIND_CMD_0A, 8'd1, 8'h00, 8'h00, 1'b0, 1'b0);
    // A command frame of kind 0A with any length but one is rejected.
    send_byte(SYNC_CMD_0A);
    send_byte(8'd2);
    // The rejected length here is itself a sync value and must not open a frame.
    send_byte(SYNC_CMD_0A);
    send_byte(SYNC_DATA);
    send_frame(KIND_CMD_0B, 8'd1, 8'h00, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_length_limits();
    kind_t k;
    drain();
    send_idle_pct = 81;
    stall_pct = 24;
    write_reg(CFG_DATA_MAX, 8'd2);
    write_reg(CFG_ANN_MAX, 8'd1);
    write_reg(CFG_CMD_MAX, 8'd1);
    write_reg(CFG_DISP_MAX, 8'd1);
    for (int i = 0; i <= 5; i++) begin
      k = kind_t'(i);
      send_frame(k, lower_len(k), 8'h00, 8'h00, 1'b0, 1'b0);
      send_byte(sync_of(k));
      send_byte(upper_len(k) + 8'd1);
      send_byte(sync_of(k));
      send_byte(lower_len(k) - 8'd1);
    end
    drain();
    write_reg(CFG_ENABLED, 8'h00);
    write_reg(CFG_DATA_MAX, 8'd128);
    write_reg(CFG_ANN_MAX, 8'd128);
    write_reg(CFG_CMD_MAX, 8'd128);
    write_reg(CFG_DISP_MAX, 8'd128);
    send_frame(KIND_DATA, 8'd128, FUNC_0C, SUB_01, 1'b1, 1'b0);
    send_frame(KIND_DISPLAY, 8'd128, 8'h00, 8'h00, 1'b0, 1'b0);
    send_frame(KIND_DISPLAY, DISP_HDR_ONE, DISP_HDR_TWO, DISP_HDR_THREE, 1'b1, 1'b0);
    for (int i = 0; i <= 5; i++) begin
      k = kind_t'(i);
      send_byte(sync_of(k));
      send_byte(8'd129);
    end
    send_byte(SYNC_DATA);
    send_byte(8'hFF);
  endtask

  task automatic test_random_frames(input int idle_pct, input int hold_pct, input int target);
    int         start;
    int         pick;
    kind_t      k;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] len;
    logic [7:0] func;
    logic [7:0] sub;
    bit         hdr;
    drain();
    write_reg(CFG_ENABLED, $urandom_range(1) ? 8'h7F : 8'($urandom_range(127)));
    write_reg(CFG_DATA_MAX, pick_limit(2));
    write_reg(CFG_ANN_MAX, pick_limit(1));
    write_reg(CFG_CMD_MAX, pick_limit(1));
    write_reg(CFG_DISP_MAX, pick_limit(1));
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    start = bytes_in_frames;
    while (bytes_in_frames - start < target) begin
      pick = $urandom_range(99);
      k = kind_t'($urandom_range(5));
      lo = lower_len(k);
      hi = (k == KIND_CMD_0A) ? 8'd1 : upper_len(k);
      if (pick < 8) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else if (pick < 15) begin
        send_byte(sync_of(k));
        case ($urandom_range(2))
          0:       send_byte(lo - 8'd1);
          1:       send_byte(hi + 8'd1);
          default: send_byte(8'($urandom_range(255)));
        endcase
      end else begin
        pick = $urandom_range(99);
        if (pick < 80) len = 8'($urandom_range((hi < lo + 8'd7) ? hi : lo + 8'd7, lo));
        else if (pick < 95) len = 8'($urandom_range(hi, lo));
        else len = hi;
        hdr = 1'b0;
        func = 8'h00;
        sub = 8'h00;
        if (k == KIND_DATA && $urandom_range(99) < 60) begin
          hdr = 1'b1;
          case ($urandom_range(5))
            0:       {func, sub} = {FUNC_0B, SUB_01};
            1:       {func, sub} = {FUNC_24, SUB_01};
            2:       {func, sub} = {FUNC_0C, SUB_01};
            3:       {func, sub} = {FUNC_0D, SUB_01};
            4:       {func, sub} = {FUNC_0C, SUB_02};
            default: {func, sub} = 16'($urandom());
          endcase
        end else if (k == KIND_DISPLAY && hi >= DISP_HDR_ONE && $urandom_range(99) < 50) begin
          hdr = 1'b1;
          len = DISP_HDR_ONE;
          func = ($urandom_range(99) < 85) ? DISP_HDR_TWO : 8'($urandom_range(255));
          sub = ($urandom_range(99) < 80) ? DISP_HDR_THREE : 8'($urandom_range(255));
        end else if (k == KIND_ANNOUNCE && hi >= ANN_HDR_ONE && $urandom_range(99) < 50) begin
          hdr = 1'b1;
          len = ($urandom_range(99) < 85) ? ANN_HDR_ONE : 8'($urandom_range(hi, lo));
          func = ($urandom_range(99) < 85) ? ANN_HDR_TWO : 8'($urandom_range(255));
          case ($urandom_range(2))
            0:       sub = FUNC_0B;
            1:       sub = FUNC_0C;
            default: sub = 8'($urandom_range(255));
          endcase
        end
        send_frame(k, len, func, sub, hdr, $urandom_range(99) < 10);
      end
    end
  endtask

  initial begin
    clear_model();
    send_idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_length_limits();
    test_random_frames(24, 81, 480);
    test_random_frames(81, 24, 480);
    test_random_frames(0, 0, 480);
    drain();
    $display("Covered %0d frame bytes and %0d skipped bytes under three idle patterns.",
             bytes_in_frames, n_skipped);
    $display("Frames ended with good checksum %0d, bad checksum %0d; lengths rejected %0d.",
             n_sum_ok, n_sum_bad, n_rejected);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bfrr_pkg.sv
rtl/bus_frame_receiver_router.sv
bench/tb_bus_frame_receiver_router.sv
